@@ hw/rtl/plt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types, constants and the pair index helper function of the proximity link tracker.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int MAX_HOSTS    = 32;
   localparam int COORD_BITS   = 24;
   localparam int TIME_BITS    = 48;
   localparam int RADIUS_BITS  = 24;
   localparam int NODE_ID_W    = 6;
   localparam int HOST_COUNT_W = 6;
   localparam int HOST_W       = $clog2(MAX_HOSTS);
   localparam int CNT_W        = $clog2(MAX_HOSTS + 1);
   localparam int PAIR_COUNT   = MAX_HOSTS * (MAX_HOSTS - 1) / 2;
   localparam int PAIR_W       = $clog2(PAIR_COUNT);
   localparam int SQ_W         = 2 * RADIUS_BITS;
   localparam int ACC_W        = SQ_W + 1;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   typedef struct packed {
      logic [NODE_ID_W-1:0]         node_id;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [TIME_BITS-1:0]         time_now;
   } req_type;

   typedef struct packed {
      logic [HOST_W-1:0]    peer_id;
      logic                 link_up;
      logic [TIME_BITS-1:0] event_time;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [HOST_COUNT_W-1:0] host_count;
      logic [RADIUS_BITS-1:0]  link_radius;
   } cfg_type;

   typedef enum logic [0:0] {
      REG_HOST_COUNT  = 1'b0,
      REG_LINK_RADIUS = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      MAC_IDLE = 2'd0,
      MAC_LOAD = 2'd1,
      MAC_ADD  = 2'd2
   } mac_op_type;

   typedef struct packed {
      mac_op_type             op;
      logic [RADIUS_BITS-1:0] operand;
   } mac_req_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RSQ,
      S_DIFF,
      S_SQX,
      S_SQY,
      S_CMP,
      S_FINISH
   } state_type;

   // Flat index of the unordered pair (hi, lo) with hi > lo.
   function automatic logic [PAIR_W-1:0] pair_index(input logic [HOST_W-1:0] hi,
                                                    input logic [HOST_W-1:0] lo);
      logic [2*HOST_W-1:0] tri_num;
      tri_num = (2*HOST_W)'(hi) * (2*HOST_W)'(hi - HOST_W'(1));
      return PAIR_W'(tri_num >> 1) + PAIR_W'(lo);
   endfunction

endpackage

@@ hw/rtl/proximity_link_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_link_tracker_unit
// Tracks pairwise proximity links between nodes from position reports.
// ----------------------------------------------------------------------------
// A report is accepted when start is high and busy is low. The node position
// is stored, then every other node in use is tested in ascending id order
// against the squared link radius, one shared squaring unit doing the work.
// A node pair whose link state flips yields one result on rsp_data, marked by
// rsp_strobe for a single cycle; the final result of a report has last set.
// The receiver cannot stall, so results must be taken when shown.
// A report walks these steps: store the node and square the radius, latch
// the squared radius, then for each tested peer the difference, two squares
// and the compare, a step for the skipped own id, and a final step that
// flushes the last result. Each result is held back until the next change,
// or the end of the walk, tells whether it is the last, so it is shown in the
// cycle after the next changing compare or after the flush. Reports with an
// id at or above the host count are dropped in the cycle they arrive.
// After reset the pair link memory is cleared, one entry per cycle, which
// keeps busy high until every entry is cleared; register writes are taken
// meanwhile.
// ----------------------------------------------------------------------------
module proximity_link_tracker_unit import plt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg;
   mac_req_type     mac_req;
   logic [ACC_W-1:0] acc;

   state_type state_ff;
   state_type state_in;

   logic signed [COORD_BITS-1:0] node_x_ff [MAX_HOSTS];
   logic signed [COORD_BITS-1:0] node_y_ff [MAX_HOSTS];

   logic [PAIR_W-1:0]            clr_ff,      clr_in;
   logic [HOST_W-1:0]            id_ff,       id_in;
   logic [HOST_W-1:0]            peer_ff,     peer_in;
   logic [CNT_W-1:0]             count_ff,    count_in;
   logic signed [COORD_BITS-1:0] cur_x_ff,    cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff,    cur_y_in;
   logic [TIME_BITS-1:0]         time_ff,     time_in;
   logic [SQ_W-1:0]              r2_ff,       r2_in;
   logic [RADIUS_BITS-1:0]       dx_ff,       dx_in;
   logic [RADIUS_BITS-1:0]       dy_ff,       dy_in;
   logic                         far_ff,      far_in;
   logic [PAIR_W-1:0]            k_ff,        k_in;
   rsp_type                      pend_ff,     pend_in;
   logic                         pend_valid_ff, pend_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]         count_eff;
   logic                     accept;
   logic                     id_ok;
   logic                     node_wr;
   logic [HOST_W-1:0]        req_idx;
   logic                     last_peer;
   logic                     self_peer;
   logic signed [COORD_BITS-1:0] peer_x;
   logic signed [COORD_BITS-1:0] peer_y;
   logic [COORD_BITS:0]      diff_x;
   logic [COORD_BITS:0]      diff_y;
   logic [COORD_BITS:0]      abs_x;
   logic [COORD_BITS:0]      abs_y;
   logic [HOST_W-1:0]        pair_hi;
   logic [HOST_W-1:0]        pair_lo;
   logic [PAIR_W-1:0]        pair_k;
   logic                     linked;

   logic              ram_wr_en;
   logic [PAIR_W-1:0] ram_wr_addr;
   logic [0:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [0:0]        ram_rd_data;

   plt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   plt_mac u_mac (
      .clock   (clock),
      .mac_req (mac_req),
      .acc     (acc)
   );

   plt_ram #(
      .WIDTH (1),
      .DEPTH (PAIR_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pair_k),
      .rd_data (ram_rd_data)
   );

   // Host counts above the table size are clamped to it.
   always_comb begin
      if (int'(cfg.host_count) > MAX_HOSTS) begin
         count_eff = CNT_W'(MAX_HOSTS);
      end else begin
         count_eff = CNT_W'(cfg.host_count);
      end
   end

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start & ~busy;
   assign id_ok   = int'(req_data.node_id) < int'(count_eff);
   assign node_wr = accept & id_ok;
   assign req_idx = HOST_W'(req_data.node_id);

   assign last_peer = (CNT_W'(peer_ff) + CNT_W'(1)) == count_ff;
   assign self_peer = (peer_ff == id_ff);

   // Delta magnitudes; any delta of 2^RADIUS_BITS or more is never in range.
   always_comb begin
      peer_x  = node_x_ff[peer_ff];
      peer_y  = node_y_ff[peer_ff];
      diff_x  = {cur_x_ff[COORD_BITS-1], cur_x_ff} - {peer_x[COORD_BITS-1], peer_x};
      diff_y  = {cur_y_ff[COORD_BITS-1], cur_y_ff} - {peer_y[COORD_BITS-1], peer_y};
      abs_x   = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
      abs_y   = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
      pair_hi = (id_ff > peer_ff) ? id_ff : peer_ff;
      pair_lo = (id_ff > peer_ff) ? peer_ff : id_ff;
      pair_k  = pair_index(pair_hi, pair_lo);
      linked  = ~far_ff & (ACC_W'(r2_ff) > acc);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == PAIR_W'(PAIR_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (node_wr) begin
               state_in = S_RSQ;
            end
         end
         S_RSQ: state_in = S_DIFF;
         S_DIFF: begin
            if (!self_peer) begin
               state_in = S_SQX;
            end else if (last_peer) begin
               state_in = S_FINISH;
            end
         end
         S_SQX: state_in = S_SQY;
         S_SQY: state_in = S_CMP;
         S_CMP: state_in = last_peer ? S_FINISH : S_DIFF;
         S_FINISH: state_in = S_IDLE;
      endcase
   end

   // Datapath and output values.
   always_comb begin
      clr_in        = clr_ff;
      id_in         = id_ff;
      peer_in       = peer_ff;
      count_in      = count_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      time_in       = time_ff;
      r2_in         = r2_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      far_in        = far_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = 1'b0;
      mac_req.op      = MAC_IDLE;
      mac_req.operand = dx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = k_ff;
      ram_wr_data   = 1'b0;
      ram_rd_en     = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + PAIR_W'(1);
         end
         S_IDLE: begin
            if (node_wr) begin
               id_in           = req_idx;
               peer_in         = '0;
               count_in        = count_eff;
               cur_x_in        = req_data.pos_x;
               cur_y_in        = req_data.pos_y;
               time_in         = req_data.time_now;
               pend_valid_in   = 1'b0;
               mac_req.op      = MAC_LOAD;
               mac_req.operand = cfg.link_radius;
            end
         end
         S_RSQ: begin
            r2_in = SQ_W'(acc);
         end
         S_DIFF: begin
            if (self_peer) begin
               peer_in = peer_ff + HOST_W'(1);
            end else begin
               dx_in     = RADIUS_BITS'(abs_x);
               dy_in     = RADIUS_BITS'(abs_y);
               far_in    = ((abs_x >> RADIUS_BITS) != '0) || ((abs_y >> RADIUS_BITS) != '0);
               k_in      = pair_k;
               ram_rd_en = 1'b1;
            end
         end
         S_SQX: begin
            mac_req.op      = MAC_LOAD;
            mac_req.operand = dx_ff;
         end
         S_SQY: begin
            mac_req.op      = MAC_ADD;
            mac_req.operand = dy_ff;
         end
         S_CMP: begin
            peer_in = peer_ff + HOST_W'(1);
            if (linked != ram_rd_data[0]) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = linked;
               // A held result is released once a later change proves it is not last.
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_ff;
               end
               pend_in.peer_id    = peer_ff;
               pend_in.link_up    = linked;
               pend_in.event_time = time_ff;
               pend_in.last       = 1'b0;
               pend_valid_in      = 1'b1;
            end
         end
         S_FINISH: begin
            if (pend_valid_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = pend_ff;
               rsp_data_in.last = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_HOSTS; i++) begin
            node_x_ff[i] <= '0;
            node_y_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (node_wr) begin
            node_x_ff[req_idx] <= req_data.pos_x;
            node_y_ff[req_idx] <= req_data.pos_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      peer_ff     <= peer_in;
      count_ff    <= count_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      time_ff     <= time_in;
      r2_ff       <= r2_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      far_ff      <= far_in;
      k_ff        <= k_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Results only leave from the compare step or the final flush.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == S_CMP || $past(state_ff) == S_FINISH))
      else $error("result strobe outside compare or flush");

   // The last result of a report ends the walk, so no result follows at once.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |=> !rsp_strobe)
      else $error("result directly after last result");

   // No held-back result may survive into the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over in idle");

endmodule

@@ hw/rtl/plt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module plt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/plt_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_mac
// Shared squaring unit with an accumulator, used for the radius and both
// coordinate deltas.
// ----------------------------------------------------------------------------
module plt_mac import plt_pkg::*; (
   input  logic             clock,
   input  mac_req_type      mac_req,
   output logic [ACC_W-1:0] acc
);

   logic [SQ_W-1:0]  square;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;

   always_comb begin
      square = SQ_W'(mac_req.operand) * SQ_W'(mac_req.operand);
      case (mac_req.op)
         MAC_LOAD: acc_in = ACC_W'(square);
         MAC_ADD:  acc_in = acc_ff + ACC_W'(square);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ hw/rtl/plt_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_csr
// APB-style register file holding the host count and the link radius.
// ----------------------------------------------------------------------------
module plt_csr import plt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [HOST_COUNT_W-1:0] host_count_ff;
   logic [HOST_COUNT_W-1:0] host_count_in;
   logic [RADIUS_BITS-1:0]  link_radius_ff;
   logic [RADIUS_BITS-1:0]  link_radius_in;
   csr_reg_type             reg_sel;
   logic                    wr_stb;

   assign pready  = 1'b1;
   assign reg_sel = csr_reg_type'(paddr[2]);
   assign wr_stb  = psel & penable & pwrite & pready;

   always_comb begin
      host_count_in  = host_count_ff;
      link_radius_in = link_radius_ff;
      prdata         = '0;
      unique case (reg_sel)
         REG_HOST_COUNT: begin
            prdata = CSR_DATA_W'(host_count_ff);
            if (wr_stb) begin
               host_count_in = HOST_COUNT_W'(pwdata);
            end
         end
         REG_LINK_RADIUS: begin
            prdata = CSR_DATA_W'(link_radius_ff);
            if (wr_stb) begin
               link_radius_in = RADIUS_BITS'(pwdata);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_count_ff  <= HOST_COUNT_W'(32);
         link_radius_ff <= '0;
      end else begin
         host_count_ff  <= host_count_in;
         link_radius_ff <= link_radius_in;
      end
   end

   assign cfg.host_count  = host_count_ff;
   assign cfg.link_radius = link_radius_ff;

endmodule
